// ===== hdl/lps_pkg.sv =====
// Shared constants and types for the linear prime sieve.
// Used by lps_rem, linear_prime_sieve and the bench; no other dependencies.
package lps_pkg;

   localparam int LPS_MAX_N_DEFAULT       = 65535;
   localparam int LPS_PRIME_DEPTH_DEFAULT = 8192;

   localparam int LPS_LIMIT_W = 16;
   localparam int LPS_VALUE_W = 16;
   localparam int LPS_COUNT_W = 14;

   localparam logic [LPS_LIMIT_W-1:0] LPS_LIMIT_RESET = 16'hFFFF;

   // Status of the serial remainder unit as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic zero;
   } lps_div_status_type;

endpackage

// ===== hdl/lps_rem.sv =====
// Serial divisibility checker: restoring remainder, one dividend bit per cycle.
// Depends on lps_pkg for the status struct.
module lps_rem #(
   parameter int NW = lps_pkg::LPS_VALUE_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [NW-1:0]               dividend,
   input  logic [NW-1:0]               divisor,
   output lps_pkg::lps_div_status_type status
);
   import lps_pkg::*;

   localparam int CNTW = $clog2(NW + 1);

   logic            busy_ff, busy_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]   rem_ff, rem_in;
   logic [NW-1:0]   dvd_ff, dvd_in;
   logic [NW-1:0]   dvs_ff, dvs_in;
   logic [NW:0]     trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, dvd_ff[NW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(NW);
         rem_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so NW bits hold it.
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = NW'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[NW-1:0];
         end
         dvd_in = {dvd_ff[NW-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.zero = (rem_ff == '0);

endmodule

// ===== hdl/linear_prime_sieve.sv =====
// Linear prime sieve on lps_pkg and lps_rem: one integer per transaction, 1-bit mark memory.
// Each transaction walks S_START and S_MARK, then per listed prime S_FETCH, S_PRIME, S_CHECK
// and S_DIV (remainder unit, NW = bits of MAX_N), then S_FIN; past the limit, S_START and S_FIN.
// A new transaction is taken only once the last is through; a stalled result holds the next one.
// Reset clears all MAX_N+1 marks, taking no transaction; a restart first clears marks up to
// the highest index marked so far.
module linear_prime_sieve #(
   parameter int MAX_N       = lps_pkg::LPS_MAX_N_DEFAULT,
   parameter int PRIME_DEPTH = lps_pkg::LPS_PRIME_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_restart,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lps_pkg::LPS_VALUE_W-1:0] rsp_value,
   output logic                            rsp_is_prime,
   output logic [lps_pkg::LPS_COUNT_W-1:0] rsp_prime_count,
   output logic                            rsp_done_res,
   input  logic                            csr_we,
   input  logic [lps_pkg::LPS_LIMIT_W-1:0] csr_wdata
);
   import lps_pkg::*;

   localparam int NW   = $clog2(MAX_N + 1);
   localparam int AW   = $clog2(PRIME_DEPTH);
   localparam int CW   = $clog2(PRIME_DEPTH + 1);
   localparam int LIMW = (NW > LPS_LIMIT_W) ? NW : LPS_LIMIT_W;
   localparam int MARK_DEPTH = MAX_N + 1;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_START = 4'd2;
   localparam logic [3:0] S_MARK  = 4'd3;
   localparam logic [3:0] S_FETCH = 4'd4;
   localparam logic [3:0] S_PRIME = 4'd5;
   localparam logic [3:0] S_CHECK = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;

   // Memories
   logic           marks [MARK_DEPTH];
   logic [NW-1:0]  plist [PRIME_DEPTH];

   logic [3:0]     state_ff, state_in;
   logic [LPS_LIMIT_W-1:0] limit_ff;
   logic [NW:0]    next_ff, next_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [CW-1:0]  j_ff, j_in;
   logic [NW-1:0]  hw_ff, hw_in;
   logic [NW-1:0]  clr_addr_ff, clr_addr_in;
   logic [NW-1:0]  clr_end_ff, clr_end_in;
   logic           pend_ff, pend_in;
   logic           restart_ff, restart_in;
   logic           past_ff, past_in;
   logic           prime_ff, prime_in;
   logic [2*NW-1:0] prod_ff;

   logic           mark_we, mark_wdata, mark_re, mark_rd_ff;
   logic [NW-1:0]  mark_waddr;
   logic           pl_we, pl_re;
   logic [NW-1:0]  pl_rd_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [LPS_VALUE_W-1:0] rsp_value_ff;
   logic           rsp_prime_ff;
   logic [LPS_COUNT_W-1:0] rsp_count_ff;
   logic           rsp_done_ff;
   logic           rsp_load, out_free;

   logic [LIMW-1:0] lim_wide;
   logic [NW-1:0]  lim;
   logic [NW-1:0]  cur;
   logic [NW-1:0]  prod_nw;
   logic [NW+LPS_VALUE_W-1:0] val_ext;
   logic [CW+LPS_COUNT_W-1:0] cnt_ext;
   logic           div_start;
   lps_div_status_type div_st;

   // Effective limit is the smaller of the register and MAX_N.
   always_comb begin
      lim_wide = LIMW'(limit_ff);
      if (lim_wide > LIMW'(MAX_N)) begin
         lim_wide = LIMW'(MAX_N);
      end
   end
   assign lim     = lim_wide[NW-1:0];
   assign cur     = next_ff[NW-1:0];
   assign prod_nw = prod_ff[NW-1:0];
   assign val_ext = (NW+LPS_VALUE_W)'(cur);
   assign cnt_ext = (CW+LPS_COUNT_W)'(cnt_ff);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in    = state_ff;
      next_in     = next_ff;
      cnt_in      = cnt_ff;
      j_in        = j_ff;
      hw_in       = hw_ff;
      clr_addr_in = clr_addr_ff;
      clr_end_in  = clr_end_ff;
      pend_in     = pend_ff;
      restart_in  = restart_ff;
      past_in     = past_ff;
      prime_in    = prime_ff;
      mark_we     = 1'b0;
      mark_waddr  = clr_addr_ff;
      mark_wdata  = 1'b0;
      mark_re     = 1'b0;
      pl_we       = 1'b0;
      pl_re       = 1'b0;
      div_start   = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            mark_we     = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == clr_end_ff) begin
               cnt_in     = '0;
               next_in    = (NW+1)'(2);
               hw_in      = '0;
               restart_in = 1'b0;
               pend_in    = 1'b0;
               state_in   = pend_ff ? S_START : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               restart_in = req_restart;
               state_in   = S_START;
            end
         end
         S_START: begin
            if (restart_ff) begin
               clr_addr_in = '0;
               clr_end_in  = hw_ff;
               pend_in     = 1'b1;
               state_in    = S_CLEAR;
            end else if (next_ff > {1'b0, lim}) begin
               past_in  = 1'b1;
               state_in = S_FIN;
            end else begin
               past_in  = 1'b0;
               mark_re  = 1'b1;
               state_in = S_MARK;
            end
         end
         S_MARK: begin
            prime_in = !mark_rd_ff;
            j_in     = '0;
            if (!mark_rd_ff && (cnt_ff < CW'(PRIME_DEPTH))) begin
               pl_we  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
            state_in = S_FETCH;
         end
         S_FETCH: begin
            if (j_ff >= cnt_ff) begin
               state_in = S_FIN;
            end else begin
               pl_re    = 1'b1;
               state_in = S_PRIME;
            end
         end
         S_PRIME: begin
            div_start = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            if (prod_ff > (2*NW)'(lim)) begin
               state_in = S_FIN;
            end else begin
               mark_we    = 1'b1;
               mark_waddr = prod_nw;
               mark_wdata = 1'b1;
               if (prod_nw > hw_ff) begin
                  hw_in = prod_nw;
               end
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!div_st.busy) begin
               if (div_st.zero) begin
                  state_in = S_FIN;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = S_FETCH;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (!past_ff) begin
                  next_in = next_ff + 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         limit_ff     <= LPS_LIMIT_RESET;
         next_ff      <= (NW+1)'(2);
         cnt_ff       <= '0;
         j_ff         <= '0;
         hw_ff        <= '0;
         clr_addr_ff  <= '0;
         clr_end_ff   <= NW'(MAX_N);
         pend_ff      <= 1'b0;
         restart_ff   <= 1'b0;
         past_ff      <= 1'b0;
         prime_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         next_ff      <= next_in;
         cnt_ff       <= cnt_in;
         j_ff         <= j_in;
         hw_ff        <= hw_in;
         clr_addr_ff  <= clr_addr_in;
         clr_end_ff   <= clr_end_in;
         pend_ff      <= pend_in;
         restart_ff   <= restart_in;
         past_ff      <= past_in;
         prime_ff     <= prime_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Product of the integer and the prime just read; compared in the next cycle.
   always_ff @(posedge clock) begin
      if (state_ff == S_PRIME) begin
         prod_ff <= cur * pl_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         marks[mark_waddr] <= mark_wdata;
      end
      if (mark_re) begin
         mark_rd_ff <= marks[cur];
      end
   end

   always_ff @(posedge clock) begin
      if (pl_we) begin
         plist[cnt_ff[AW-1:0]] <= cur;
      end
      if (pl_re) begin
         pl_rd_ff <= plist[j_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (past_ff) begin
            rsp_value_ff <= '0;
            rsp_prime_ff <= 1'b0;
            rsp_done_ff  <= 1'b1;
         end else begin
            rsp_value_ff <= val_ext[LPS_VALUE_W-1:0];
            rsp_prime_ff <= prime_ff;
            rsp_done_ff  <= (cur == lim);
         end
         rsp_count_ff <= cnt_ext[LPS_COUNT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_is_prime    = rsp_prime_ff;
   assign rsp_prime_count = rsp_count_ff;
   assign rsp_done_res    = rsp_done_ff;

   lps_rem #(
      .NW(NW)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cur),
      .divisor  (pl_rd_ff),
      .status   (div_st)
   );

   // The prime list count never runs past the list depth.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(PRIME_DEPTH))
      else $error("prime count exceeds list depth");

   // A composite mark is only set at a product within the effective limit.
   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      (mark_we && mark_wdata) |-> (prod_ff <= (2*NW)'(lim)))
      else $error("composite mark written beyond limit");

   // The high-water mark covers every mark set, so a restart clears it.
   a_hw_covers: assert property (@(posedge clock) disable iff (reset)
      (mark_we && mark_wdata) |=> (hw_ff >= $past(mark_waddr)))
      else $error("high-water mark missed a composite mark");

   // The remainder check has finished before the sequencer acts on it.
   a_div_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && state_in != S_DIV) |-> !div_st.busy)
      else $error("divisibility result used while unit busy");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for linear_prime_sieve: a directed table of steps, then random
// sieve runs under many limits, each result checked against its typed row or an in-bench sieve.
// Depends on lps_pkg and the linear_prime_sieve RTL.
module tb;
   import lps_pkg::*;

   localparam int MARK_TOP     = LPS_MAX_N_DEFAULT;
   localparam int PRIME_SLOTS  = LPS_PRIME_DEPTH_DEFAULT;
   localparam int RANDOM_STEPS = 1750;
   localparam int WIDE_STEPS   = 250;
   localparam int QUIET_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 2000;

   typedef struct packed {
      logic [LPS_VALUE_W-1:0] value;
      logic                   prime_flag;
      logic [LPS_COUNT_W-1:0] count;
      logic                   done;
   } sieve_result_type;

   typedef struct packed {
      logic                   set_limit;
      logic [LPS_LIMIT_W-1:0] limit;
      logic                   restart;
      logic                   typed;
      sieve_result_type       want;
   } sieve_row_type;

   // Rows with typed = 0 are checked against the sieve model only.
   localparam sieve_row_type STEP_PLAN [23] = '{
      '{1'b0, 16'd0,     1'b0, 1'b1, '{16'd2,  1'b1, 14'd1, 1'b0}},
      '{1'b0, 16'd0,     1'b0, 1'b1, '{16'd3,  1'b1, 14'd2, 1'b0}},
      '{1'b0, 16'd0,     1'b0, 1'b1, '{16'd4,  1'b0, 14'd2, 1'b0}},
      '{1'b0, 16'd0,     1'b1, 1'b1, '{16'd2,  1'b1, 14'd1, 1'b0}},
      '{1'b1, 16'd2,     1'b1, 1'b1, '{16'd2,  1'b1, 14'd1, 1'b1}},
      '{1'b0, 16'd0,     1'b0, 1'b1, '{16'd0,  1'b0, 14'd1, 1'b1}},
      '{1'b1, 16'd0,     1'b1, 1'b1, '{16'd0,  1'b0, 14'd0, 1'b1}},
      '{1'b1, 16'd1,     1'b0, 1'b1, '{16'd0,  1'b0, 14'd0, 1'b1}},
      '{1'b1, 16'd10,    1'b1, 1'b1, '{16'd2,  1'b1, 14'd1, 1'b0}},
      '{1'b0, 16'd0,     1'b0, 1'b1, '{16'd3,  1'b1, 14'd2, 1'b0}},
      '{1'b0, 16'd0,     1'b0, 1'b1, '{16'd4,  1'b0, 14'd2, 1'b0}},
      '{1'b0, 16'd0,     1'b0, 1'b1, '{16'd5,  1'b1, 14'd3, 1'b0}},
      '{1'b0, 16'd0,     1'b0, 1'b1, '{16'd6,  1'b0, 14'd3, 1'b0}},
      '{1'b0, 16'd0,     1'b0, 1'b1, '{16'd7,  1'b1, 14'd4, 1'b0}},
      '{1'b0, 16'd0,     1'b0, 1'b1, '{16'd8,  1'b0, 14'd4, 1'b0}},
      '{1'b0, 16'd0,     1'b0, 1'b1, '{16'd9,  1'b0, 14'd4, 1'b0}},
      '{1'b0, 16'd0,     1'b0, 1'b1, '{16'd10, 1'b0, 14'd4, 1'b1}},
      '{1'b0, 16'd0,     1'b0, 1'b1, '{16'd0,  1'b0, 14'd4, 1'b1}},
      // Raising the limit without a restart: 12 was skipped earlier and stays unmarked.
      '{1'b1, 16'd30,    1'b0, 1'b0, '0},
      '{1'b0, 16'd0,     1'b0, 1'b0, '0},
      '{1'b0, 16'd0,     1'b0, 1'b0, '0},
      '{1'b1, 16'hFFFF,  1'b1, 1'b1, '{16'd2,  1'b1, 14'd1, 1'b0}},
      '{1'b0, 16'd0,     1'b0, 1'b0, '0}
   };

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   logic                   req_restart = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   logic [LPS_VALUE_W-1:0] rsp_value;
   logic                   rsp_is_prime;
   logic [LPS_COUNT_W-1:0] rsp_prime_count;
   logic                   rsp_done_res;
   logic                   csr_we      = 1'b0;
   logic [LPS_LIMIT_W-1:0] csr_wdata   = '0;

   // Sieve model state.
   bit                     composite [0:MARK_TOP];
   bit [15:0]              prime_tab [0:PRIME_SLOTS-1];
   bit [13:0]              primes_found = '0;
   bit [16:0]              next_int     = 17'd2;
   bit [LPS_LIMIT_W-1:0]   limit_reg    = LPS_LIMIT_RESET;
   int                     composite_hi = 0;

   sieve_result_type       sieve_due [$];
   int                     mismatches   = 0;
   int                     steps_sent   = 0;
   int                     quiet_cycles = 0;
   bit                     calm         = 1'b0;

   linear_prime_sieve u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_is_prime    (rsp_is_prime),
      .rsp_prime_count (rsp_prime_count),
      .rsp_done_res    (rsp_done_res),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Advances the sieve model by one integer (none past the limit) and returns the result it reports.
   function automatic sieve_result_type sieve_advance(input bit restart);
      sieve_result_type r;
      bit [16:0]        lim;
      bit [16:0]        cur;
      bit [32:0]        prod;
      bit [15:0]        p;
      bit               fresh_prime;
      lim = (limit_reg > MARK_TOP) ? 17'(MARK_TOP) : {1'b0, limit_reg};
      if (restart) begin
         for (int i = 0; i <= composite_hi; i++) composite[i[15:0]] = 1'b0;
         composite_hi = 0;
         primes_found = '0;
         next_int = 17'd2;
      end
      cur = next_int;
      if (cur > lim) begin
         r.value      = '0;
         r.prime_flag = 1'b0;
         r.count      = primes_found;
         r.done       = 1'b1;
         return r;
      end
      fresh_prime = !composite[cur[15:0]];
      if (fresh_prime && primes_found < PRIME_SLOTS) begin
         prime_tab[primes_found[12:0]] = cur[15:0];
         primes_found++;
      end
      for (int j = 0; j < primes_found; j++) begin
         p = prime_tab[j[12:0]];
         prod = cur * p;
         if (p == 0 || prod > lim) break;
         composite[prod[15:0]] = 1'b1;
         if (prod > composite_hi) composite_hi = int'(prod);
         if (cur % p == 0) break;
      end
      next_int = cur + 17'd1;
      r.value      = cur[15:0];
      r.prime_flag = fresh_prime;
      r.count      = primes_found;
      r.done       = (cur == lim);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
   endtask

   // Writes the limit once every outstanding transaction has returned.
   task automatic write_limit(input logic [LPS_LIMIT_W-1:0] v);
      req_valid <= 1'b0;
      while (sieve_due.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      limit_reg = v;
   endtask

   task automatic offer_step(input bit restart, input bit typed, input sieve_result_type want);
      int               gap;
      sieve_result_type got;
      gap = calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid   <= 1'b0;
         req_restart <= 1'($urandom_range(0, 1));
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      got = sieve_advance(restart);
      sieve_due.insert(sieve_due.size(), typed ? want : got);
      steps_sent++;
   endtask

   initial begin
      int                     pick;
      int                     run;
      bit                     fresh;
      logic [LPS_LIMIT_W-1:0] next_limit;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (STEP_PLAN[i]) begin
         if (STEP_PLAN[i].set_limit) write_limit(STEP_PLAN[i].limit);
         offer_step(STEP_PLAN[i].restart, STEP_PLAN[i].typed, STEP_PLAN[i].want);
      end

      // Mostly whole runs from 2 past the limit, broken now and then by a restart
      // or by a limit change that leaves the sieve where it is.
      while (steps_sent < RANDOM_STEPS) begin
         pick = $urandom_range(0, 99);
         calm = ($urandom_range(0, 3) == 0);
         if (pick < 8) next_limit = 16'($urandom_range(0, 2));
         else if (pick < 80) next_limit = 16'($urandom_range(3, 80));
         else next_limit = 16'($urandom_range(81, 1500));
         if ($urandom_range(0, 4) != 0) write_limit(next_limit);
         fresh = ($urandom_range(0, 9) < 7);
         run = $urandom_range(10, 120);
         for (int k = 0; k < run; k++)
            offer_step(k == 0 ? fresh : ($urandom_range(0, 39) == 0), 1'b0, '0);
      end

      // One long run at the full limit reaches the large products.
      calm = 1'b0;
      write_limit(16'hFFFF);
      for (int k = 0; k < WIDE_STEPS; k++) begin
         if (k == WIDE_STEPS / 2) calm = 1'b1;
         offer_step(k == 0, 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (sieve_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && sieve_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Result side: a random hold-off before each transaction, none in calm stretches.
   initial begin
      int hold;
      forever begin
         hold = calm ? 0 : $urandom_range(0, 17);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      sieve_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sieve_due.size() == 0) begin
            report_mismatch("result with nothing pending, value", rsp_value, -1);
         end else begin
            want = sieve_due.pop_front();
            if (rsp_value !== want.value)
               report_mismatch("value", rsp_value, want.value);
            if (rsp_is_prime !== want.prime_flag)
               report_mismatch("prime flag", rsp_is_prime, want.prime_flag);
            if (rsp_prime_count !== want.count)
               report_mismatch("prime_count", rsp_prime_count, want.count);
            if (rsp_done_res !== want.done)
               report_mismatch("done_res", rsp_done_res, want.done);
         end
      end
   end

   // Watchdog: too long without any transaction on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

endmodule
